>>> rtl/cwp_pkg.sv
package cwp_pkg;

    localparam int COORD_WIDTH = 10;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES = 24;

    localparam int DELTA_W = COORD_WIDTH + 1;
    localparam int SQ_W = 2 * COORD_WIDTH + 1;
    localparam int DIST_W = COORD_WIDTH + 1;
    localparam int FRAC_W = 16;
    localparam int SAT_W = FRAC_W + 1;
    localparam int HUE_W = 15;
    localparam int ANG_W = 24;
    localparam int XY_W = COORD_WIDTH + FRAC_W + 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CHAN_W = 8;
    localparam int DEV_W = 12;
    localparam int PROD_W = 28;
    localparam int MID_W = PROD_W + 4;
    localparam int LOW_W = SAT_W + 8;

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [XY_W-1:0] xy_t;
    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic [HUE_W-1:0] hue_t;
    typedef logic [SAT_W-1:0] sat_t;
    typedef logic [CHAN_W-1:0] chan_t;

    localparam coord_t CENTER_X_RST = coord_t'(135);
    localparam coord_t CENTER_Y_RST = coord_t'(135);
    localparam coord_t RADIUS_RST = coord_t'(128);

    localparam ang_t ANG_180 = ang_t'(180 * 16384);
    localparam ang_t ANG_360 = ang_t'(360 * 16384);
    localparam hue_t HUE_FULL = hue_t'(23040);
    localparam hue_t HUE_SECTOR = hue_t'(3840);
    localparam hue_t HUE_90 = hue_t'(90 * 64);
    localparam hue_t HUE_180 = hue_t'(180 * 64);
    localparam hue_t HUE_270 = hue_t'(270 * 64);
    localparam logic [PROD_W-1:0] Y_FULL = PROD_W'(3840 * 65536);
    localparam sat_t SAT_ONE = sat_t'(65536);
    localparam chan_t CHAN_FULL = chan_t'(255);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER_X     = 2'd0,
        REG_CENTER_Y     = 2'd1,
        REG_WHEEL_RADIUS = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    typedef struct packed {
        coord_t touch_x;
        coord_t touch_y;
    } in_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } out_t;

    typedef struct packed {
        logic [SQ_W-1:0] sq;
        delta_t          dx;
        delta_t          dy;
    } sq_beat_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        delta_t            dx;
        delta_t            dy;
    } dist_beat_t;

    typedef struct packed {
        sat_t   sat;
        logic   in_wheel;
        delta_t dx;
        delta_t dy;
    } sat_beat_t;

    typedef struct packed {
        hue_t hue;
        sat_t sat;
        logic in_wheel;
    } hue_beat_t;

    // atan(2^-i) in 1/16384 degree
    function automatic ang_t atan_step(input int unsigned idx);
        ang_t a;
        unique case (idx)
            0:  a = ang_t'(737280);
            1:  a = ang_t'(435242);
            2:  a = ang_t'(229970);
            3:  a = ang_t'(116736);
            4:  a = ang_t'(58595);
            5:  a = ang_t'(29326);
            6:  a = ang_t'(14667);
            7:  a = ang_t'(7334);
            8:  a = ang_t'(3667);
            9:  a = ang_t'(1833);
            10: a = ang_t'(917);
            11: a = ang_t'(458);
            12: a = ang_t'(229);
            13: a = ang_t'(115);
            14: a = ang_t'(57);
            15: a = ang_t'(29);
            16: a = ang_t'(14);
            17: a = ang_t'(7);
            18: a = ang_t'(4);
            19: a = ang_t'(2);
            20: a = ang_t'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/cwp_front.sv
module cwp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cwp_pkg::in_t         in_data,
    input  cwp_pkg::coord_t      center_x,
    input  cwp_pkg::coord_t      center_y,
    output logic                 out_valid,
    output cwp_pkg::sq_beat_t    out_data
);

    localparam int PSQ_W = 2 * cwp_pkg::DELTA_W;

    logic              valid_a_reg;
    cwp_pkg::delta_t   dx_reg;
    cwp_pkg::delta_t   dy_reg;
    cwp_pkg::delta_t   dx_next;
    cwp_pkg::delta_t   dy_next;
    logic              valid_b_reg;
    cwp_pkg::sq_beat_t beat_reg;
    cwp_pkg::sq_beat_t beat_next;
    logic signed [PSQ_W-1:0] dx_sq;
    logic signed [PSQ_W-1:0] dy_sq;

    assign dx_next = cwp_pkg::delta_t'({1'b0, in_data.touch_x})
                   - cwp_pkg::delta_t'({1'b0, center_x});
    assign dy_next = cwp_pkg::delta_t'({1'b0, in_data.touch_y})
                   - cwp_pkg::delta_t'({1'b0, center_y});

    assign dx_sq = dx_reg * dx_reg;
    assign dy_sq = dy_reg * dy_reg;

    always_comb
    begin
        beat_next.sq = cwp_pkg::SQ_W'(dx_sq) + cwp_pkg::SQ_W'(dy_sq);
        beat_next.dx = dx_reg;
        beat_next.dy = dy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_data  = beat_reg;

endmodule

>>> rtl/cwp_sqrt.sv
module cwp_sqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cwp_pkg::sq_beat_t    in_data,
    output logic                 out_valid,
    output cwp_pkg::dist_beat_t  out_data
);

    localparam int STAGES = cwp_pkg::DIST_W;
    localparam int ROOT_W = cwp_pkg::DIST_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int CAT_W = REM_W + 2;
    localparam int PAD_W = 2 * ROOT_W;

    logic              valid_reg [STAGES];
    cwp_pkg::sq_beat_t beat_reg  [STAGES];
    logic [ROOT_W-1:0] root_reg  [STAGES];
    logic [REM_W-1:0]  rem_reg   [STAGES];

    // one root bit per stage, two radicand bits consumed
    for (genvar j = 0; j < STAGES; j++)
    begin : g_step
        localparam int PAIR = STAGES - 1 - j;

        logic              valid_in;
        cwp_pkg::sq_beat_t beat_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_in;
        logic [PAD_W-1:0]  sq_pad;
        logic [CAT_W-1:0]  rem_cat;
        logic [CAT_W-1:0]  trial;
        logic              take;
        logic [ROOT_W-1:0] root_next;
        logic [REM_W-1:0]  rem_next;

        if (j == 0)
        begin : g_head
            assign valid_in = in_valid;
            assign beat_in  = in_data;
            assign root_in  = '0;
            assign rem_in   = '0;
        end
        else
        begin : g_tail
            assign valid_in = valid_reg[j-1];
            assign beat_in  = beat_reg[j-1];
            assign root_in  = root_reg[j-1];
            assign rem_in   = rem_reg[j-1];
        end

        assign sq_pad    = PAD_W'(beat_in.sq);
        assign rem_cat   = {rem_in, sq_pad[2*PAIR +: 2]};
        assign trial     = CAT_W'({root_in, 2'b01});
        assign take      = rem_cat >= trial;
        assign rem_next  = take ? REM_W'(rem_cat - trial) : REM_W'(rem_cat);
        assign root_next = {root_in[ROOT_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                beat_reg[j] <= beat_in;
                root_reg[j] <= root_next;
                rem_reg[j]  <= rem_next;
            end
        end
    end

    assign out_valid         = valid_reg[STAGES-1];
    assign out_data.distance = root_reg[STAGES-1];
    assign out_data.dx       = beat_reg[STAGES-1].dx;
    assign out_data.dy       = beat_reg[STAGES-1].dy;

endmodule

>>> rtl/cwp_div.sv
module cwp_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cwp_pkg::dist_beat_t  in_data,
    input  cwp_pkg::coord_t      radius,
    output logic                 out_valid,
    output cwp_pkg::sat_beat_t   out_data
);

    localparam int STAGES = cwp_pkg::SAT_W;
    localparam int REM_W = cwp_pkg::DIST_W + 1;

    cwp_pkg::coord_t  radius_eff;
    logic [REM_W-1:0] divisor;

    logic             valid_reg [STAGES];
    logic [REM_W-1:0] rem_reg   [STAGES];
    cwp_pkg::sat_t    quo_reg   [STAGES];
    logic             wheel_reg [STAGES];
    cwp_pkg::delta_t  dx_reg    [STAGES];
    cwp_pkg::delta_t  dy_reg    [STAGES];

    assign radius_eff = (radius == '0) ? cwp_pkg::coord_t'(1) : radius;
    assign divisor    = REM_W'(radius_eff);

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < STAGES; k++)
    begin : g_step
        logic             valid_in;
        logic [REM_W-1:0] rem_sh;
        cwp_pkg::sat_t    quo_in;
        logic             wheel_in;
        cwp_pkg::delta_t  dx_in;
        cwp_pkg::delta_t  dy_in;
        logic             take;
        logic [REM_W-1:0] rem_next;
        cwp_pkg::sat_t    quo_next;

        if (k == 0)
        begin : g_head
            assign valid_in = in_valid;
            assign rem_sh   = REM_W'(in_data.distance);
            assign quo_in   = '0;
            assign wheel_in = in_data.distance <= cwp_pkg::DIST_W'(radius_eff);
            assign dx_in    = in_data.dx;
            assign dy_in    = in_data.dy;
        end
        else
        begin : g_tail
            assign valid_in = valid_reg[k-1];
            assign rem_sh   = {rem_reg[k-1][REM_W-2:0], 1'b0};
            assign quo_in   = quo_reg[k-1];
            assign wheel_in = wheel_reg[k-1];
            assign dx_in    = dx_reg[k-1];
            assign dy_in    = dy_reg[k-1];
        end

        assign take     = rem_sh >= divisor;
        assign rem_next = take ? (rem_sh - divisor) : rem_sh;
        assign quo_next = {quo_in[cwp_pkg::SAT_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]   <= rem_next;
                quo_reg[k]   <= quo_next;
                wheel_reg[k] <= wheel_in;
                dx_reg[k]    <= dx_in;
                dy_reg[k]    <= dy_in;
            end
        end
    end

    assign out_valid         = valid_reg[STAGES-1];
    assign out_data.sat      = quo_reg[STAGES-1];
    assign out_data.in_wheel = wheel_reg[STAGES-1];
    assign out_data.dx       = dx_reg[STAGES-1];
    assign out_data.dy       = dy_reg[STAGES-1];

endmodule

>>> rtl/cwp_cordic.sv
module cwp_cordic #(
    parameter int CORDIC_STEPS = cwp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cwp_pkg::sat_beat_t   in_data,
    output logic                 out_valid,
    output cwp_pkg::hue_beat_t   out_data
);

    localparam int N = CORDIC_STEPS + 1;

    typedef struct packed {
        cwp_pkg::sat_t sat;
        logic          in_wheel;
        logic          on_axis;
        cwp_pkg::hue_t axis_hue;
    } side_t;

    logic          valid_reg [N];
    cwp_pkg::xy_t  x_reg     [N];
    cwp_pkg::xy_t  y_reg     [N];
    cwp_pkg::ang_t z_reg     [N];
    side_t         side_reg  [N];

    cwp_pkg::xy_t  x_scaled;
    cwp_pkg::xy_t  y_scaled;
    logic          dx_neg;
    side_t         side_next;

    logic               hue_valid_reg;
    cwp_pkg::hue_beat_t hue_reg;
    cwp_pkg::hue_beat_t hue_next;
    cwp_pkg::ang_t      z_pos;
    cwp_pkg::hue_t      h_raw;
    cwp_pkg::hue_t      h_wrap;

    assign x_scaled = cwp_pkg::xy_t'($signed(in_data.dx)) <<< cwp_pkg::FRAC_W;
    assign y_scaled = cwp_pkg::xy_t'($signed(in_data.dy)) <<< cwp_pkg::FRAC_W;
    assign dx_neg   = in_data.dx[cwp_pkg::DELTA_W-1];

    always_comb
    begin
        side_next.sat      = in_data.sat;
        side_next.in_wheel = in_data.in_wheel;
        side_next.on_axis  = (in_data.dx == '0) || (in_data.dy == '0);
        priority if (in_data.dy == '0)
            side_next.axis_hue = dx_neg ? cwp_pkg::HUE_180 : '0;
        else if (in_data.dy[cwp_pkg::DELTA_W-1])
            side_next.axis_hue = cwp_pkg::HUE_270;
        else
            side_next.axis_hue = cwp_pkg::HUE_90;
    end

    // left half plane turned by 180 degrees first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= dx_neg ? -x_scaled : x_scaled;
            y_reg[0]    <= dx_neg ? -y_scaled : y_scaled;
            z_reg[0]    <= dx_neg ? cwp_pkg::ANG_180 : '0;
            side_reg[0] <= side_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        cwp_pkg::xy_t  xs;
        cwp_pkg::xy_t  ys;
        cwp_pkg::ang_t step_ang;
        logic          y_pos;

        assign xs       = x_reg[i] >>> i;
        assign ys       = y_reg[i] >>> i;
        assign step_ang = cwp_pkg::atan_step(i);
        assign y_pos    = !y_reg[i][cwp_pkg::XY_W-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= y_pos ? (x_reg[i] + ys) : (x_reg[i] - ys);
                y_reg[i+1]    <= y_pos ? (y_reg[i] - xs) : (y_reg[i] + xs);
                z_reg[i+1]    <= y_pos ? (z_reg[i] + step_ang) : (z_reg[i] - step_ang);
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign z_pos  = z_reg[N-1][cwp_pkg::ANG_W-1] ? (z_reg[N-1] + cwp_pkg::ANG_360)
                                                  : z_reg[N-1];
    assign h_raw  = z_pos[cwp_pkg::ANG_W-2:8];
    assign h_wrap = (h_raw >= cwp_pkg::HUE_FULL) ? (h_raw - cwp_pkg::HUE_FULL) : h_raw;

    always_comb
    begin
        hue_next.hue      = side_reg[N-1].on_axis ? side_reg[N-1].axis_hue : h_wrap;
        hue_next.sat      = side_reg[N-1].sat;
        hue_next.in_wheel = side_reg[N-1].in_wheel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hue_valid_reg <= 1'b0;
        else if (en)
            hue_valid_reg <= valid_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hue_reg <= hue_next;
    end

    assign out_valid = hue_valid_reg;
    assign out_data  = hue_reg;

endmodule

>>> rtl/cwp_hsv.sv
module cwp_hsv (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  cwp_pkg::hue_beat_t   in_data,
    output logic                 out_valid,
    output cwp_pkg::out_t        out_data
);

    localparam cwp_pkg::hue_t HUE_2S = cwp_pkg::hue_t'(2 * 3840);
    localparam cwp_pkg::hue_t HUE_3S = cwp_pkg::hue_t'(3 * 3840);
    localparam cwp_pkg::hue_t HUE_4S = cwp_pkg::hue_t'(4 * 3840);
    localparam cwp_pkg::hue_t HUE_5S = cwp_pkg::hue_t'(5 * 3840);

    cwp_pkg::sector_t             sector_next;
    cwp_pkg::hue_t                f_val;
    logic [cwp_pkg::DEV_W-1:0]    dev_next;

    logic                         valid1_reg;
    cwp_pkg::sector_t             sector1_reg;
    logic [cwp_pkg::DEV_W-1:0]    dev1_reg;
    cwp_pkg::sat_t                sat1_reg;
    logic                         wheel1_reg;

    logic [cwp_pkg::SAT_W+cwp_pkg::DEV_W-1:0] prod_next;
    cwp_pkg::sat_t                inv_sat;
    logic [cwp_pkg::LOW_W-1:0]    low_prod;

    logic                         valid2_reg;
    cwp_pkg::sector_t             sector2_reg;
    logic [cwp_pkg::PROD_W-1:0]   prod2_reg;
    cwp_pkg::chan_t               low2_reg;
    logic                         wheel2_reg;

    logic [cwp_pkg::PROD_W-1:0]   y_val;
    logic [cwp_pkg::MID_W-1:0]    mid_prod;
    cwp_pkg::chan_t               mid;
    cwp_pkg::out_t                rgb_next;

    logic                         valid3_reg;
    cwp_pkg::out_t                rgb_reg;

    // sector and distance of hue from the sector edge at an odd multiple of HUE_SECTOR
    always_comb
    begin
        priority if (in_data.hue >= HUE_5S)
            sector_next = cwp_pkg::SEC_MR;
        else if (in_data.hue >= HUE_4S)
            sector_next = cwp_pkg::SEC_BM;
        else if (in_data.hue >= HUE_3S)
            sector_next = cwp_pkg::SEC_CB;
        else if (in_data.hue >= HUE_2S)
            sector_next = cwp_pkg::SEC_GC;
        else if (in_data.hue >= cwp_pkg::HUE_SECTOR)
            sector_next = cwp_pkg::SEC_YG;
        else
            sector_next = cwp_pkg::SEC_RY;

        priority if (in_data.hue >= HUE_4S)
            f_val = in_data.hue - HUE_4S;
        else if (in_data.hue >= HUE_2S)
            f_val = in_data.hue - HUE_2S;
        else
            f_val = in_data.hue;

        if (f_val >= cwp_pkg::HUE_SECTOR)
            dev_next = cwp_pkg::DEV_W'(f_val - cwp_pkg::HUE_SECTOR);
        else
            dev_next = cwp_pkg::DEV_W'(cwp_pkg::HUE_SECTOR - f_val);
    end

    assign prod_next = sat1_reg * dev1_reg;
    assign inv_sat   = cwp_pkg::SAT_ONE - sat1_reg;
    assign low_prod  = {inv_sat, 8'b0} - cwp_pkg::LOW_W'(inv_sat);

    // 255 / 3840 reduces to 17 / 256
    assign y_val    = cwp_pkg::Y_FULL - prod2_reg;
    assign mid_prod = {y_val, 4'b0} + cwp_pkg::MID_W'(y_val);
    assign mid      = mid_prod[cwp_pkg::MID_W-1 -: cwp_pkg::CHAN_W];

    always_comb
    begin
        unique case (sector2_reg)
            cwp_pkg::SEC_RY:
            begin
                rgb_next.red   = cwp_pkg::CHAN_FULL;
                rgb_next.green = mid;
                rgb_next.blue  = low2_reg;
            end
            cwp_pkg::SEC_YG:
            begin
                rgb_next.red   = mid;
                rgb_next.green = cwp_pkg::CHAN_FULL;
                rgb_next.blue  = low2_reg;
            end
            cwp_pkg::SEC_GC:
            begin
                rgb_next.red   = low2_reg;
                rgb_next.green = cwp_pkg::CHAN_FULL;
                rgb_next.blue  = mid;
            end
            cwp_pkg::SEC_CB:
            begin
                rgb_next.red   = low2_reg;
                rgb_next.green = mid;
                rgb_next.blue  = cwp_pkg::CHAN_FULL;
            end
            cwp_pkg::SEC_BM:
            begin
                rgb_next.red   = mid;
                rgb_next.green = low2_reg;
                rgb_next.blue  = cwp_pkg::CHAN_FULL;
            end
            default:
            begin
                rgb_next.red   = cwp_pkg::CHAN_FULL;
                rgb_next.green = low2_reg;
                rgb_next.blue  = mid;
            end
        endcase
        if (!wheel2_reg)
            rgb_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sector1_reg <= sector_next;
            dev1_reg    <= dev_next;
            sat1_reg    <= in_data.sat;
            wheel1_reg  <= in_data.in_wheel;
            sector2_reg <= sector1_reg;
            prod2_reg   <= cwp_pkg::PROD_W'(prod_next);
            low2_reg    <= low_prod[cwp_pkg::FRAC_W +: cwp_pkg::CHAN_W];
            wheel2_reg  <= wheel1_reg;
            rgb_reg     <= rgb_next;
        end
    end

    assign out_valid = valid3_reg;
    assign out_data  = rgb_reg;

endmodule

>>> rtl/color_wheel_point_to_rgb_top.sv
// Maps a touched screen point to the RGB color under it on an HSV color wheel of full
// brightness: hue is the angle about the configured center (CORDIC, 1/64 degree), saturation
// is distance over radius, points outside the radius come out black. One point is taken per
// clock while the output is not stalled, and each beat passes through the pipeline's stages:
// two for offset and squares, eleven for the square root (one root bit each), seventeen for
// the saturation divider (one quotient bit each), one per CORDIC step plus two, and three for
// the color formula. A stall on the output holds the whole pipeline. Configuration writes are
// taken every cycle and belong in idle periods.
module color_wheel_point_to_rgb_top #(
    parameter int CORDIC_STEPS = cwp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  cwp_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cwp_pkg::out_t                     out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cwp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  cwp_pkg::coord_t                   cfg_data
);

    cwp_pkg::coord_t     center_x_reg;
    cwp_pkg::coord_t     center_y_reg;
    cwp_pkg::coord_t     radius_reg;
    logic                en;

    logic                sq_valid;
    cwp_pkg::sq_beat_t   sq_beat;
    logic                dist_valid;
    cwp_pkg::dist_beat_t dist_beat;
    logic                sat_valid;
    cwp_pkg::sat_beat_t  sat_beat;
    logic                hue_valid;
    cwp_pkg::hue_beat_t  hue_beat;

    assign en        = out_ready || !out_valid;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= cwp_pkg::CENTER_X_RST;
            center_y_reg <= cwp_pkg::CENTER_Y_RST;
            radius_reg   <= cwp_pkg::RADIUS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cwp_pkg::REG_CENTER_X:     center_x_reg <= cfg_data;
                cwp_pkg::REG_CENTER_Y:     center_y_reg <= cfg_data;
                cwp_pkg::REG_WHEEL_RADIUS: radius_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    cwp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .out_valid (sq_valid),
        .out_data  (sq_beat)
    );

    cwp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_data   (sq_beat),
        .out_valid (dist_valid),
        .out_data  (dist_beat)
    );

    cwp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dist_valid),
        .in_data   (dist_beat),
        .radius    (radius_reg),
        .out_valid (sat_valid),
        .out_data  (sat_beat)
    );

    cwp_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sat_valid),
        .in_data   (sat_beat),
        .out_valid (hue_valid),
        .out_data  (hue_beat)
    );

    cwp_hsv u_hsv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hue_valid),
        .in_data   (hue_beat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

>>> rtl/cwp_checker.sv
module cwp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input cwp_pkg::out_t out_data,
    input logic          cfg_ready
);

    // stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed under stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

    // inside the wheel one channel is always at full scale, outside the color is black
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.red == 8'd255) || (out_data.green == 8'd255)
                   || (out_data.blue == 8'd255)
                   || ((out_data.red == 8'd0) && (out_data.green == 8'd0)
                       && (out_data.blue == 8'd0)))
        else $error("color has no full channel and is not black");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind color_wheel_point_to_rgb_top cwp_checker u_checker (.*);

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cwp_pkg::*;

    localparam int LATENCY = 35 + CORDIC_STEPS_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    class color_board;
        out_t pending[$];
        int errors;

        task report(string msg);
            $display("%s", msg);
            errors++;
        endtask

        function void note_point(out_t e);
            pending.push_back(e);
        endfunction

        task check_color(out_t got);
            out_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("mismatch: unexpected beat r=%0d g=%0d b=%0d",
                                 got.red, got.green, got.blue));
                return;
            end
            e = pending.pop_front();
            if (got.red !== e.red)
                report($sformatf("mismatch red: got %0d exp %0d", got.red, e.red));
            if (got.green !== e.green)
                report($sformatf("mismatch green: got %0d exp %0d", got.green, e.green));
            if (got.blue !== e.blue)
                report($sformatf("mismatch blue: got %0d exp %0d", got.blue, e.blue));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    out_t out_data;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    coord_t cfg_data = '0;

    color_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    longint cycles = 0;
    logic [9:0] cx_m = 135, cy_m = 135, rad_m = 128;

    const longint atan_lut[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};

    always #5 clk = ~clk;

    color_wheel_point_to_rgb_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint wheel_hue(longint dx, longint dy);
        longint x, y, z, xs, ys;
        if (dy == 0)
            return dx < 0 ? 180 * 64 : 0;
        if (dx == 0)
            return dy > 0 ? 90 * 64 : 270 * 64;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 180 * 16384;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z += atan_lut[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= atan_lut[i];
            end
        end
        if (z < 0)
            z += 360 * 16384;
        z = z / 256;
        while (z >= 23040)
            z -= 23040;
        return z;
    endfunction

    function automatic longint shade(longint sat, longint k);
        return ((255 * ((65536 - sat) * 3840 + sat * k)) / (65536 * 3840)) & 255;
    endfunction

    function automatic out_t point_color(in_t p);
        longint dx, dy, sq, root, rad, sat, hue, f, w, hi, md, lo;
        sector_t sec;
        out_t c;
        dx = longint'(p.touch_x) - longint'(cx_m);
        dy = longint'(p.touch_y) - longint'(cy_m);
        sq = dx * dx + dy * dy;
        root = 0;
        while ((root + 1) * (root + 1) <= sq)
            root++;
        rad = rad_m == 0 ? 1 : rad_m;
        if (root > rad)
            return '0;
        sat = root * 65536 / rad;
        hue = wheel_hue(dx, dy);
        sec = sector_t'(hue / 3840);
        f = hue % 7680;
        w = f >= 3840 ? 7680 - f : f;
        hi = shade(sat, 3840);
        md = shade(sat, w);
        lo = shade(sat, 0);
        case (sec)
            SEC_RY: c = '{chan_t'(hi), chan_t'(md), chan_t'(lo)};
            SEC_YG: c = '{chan_t'(md), chan_t'(hi), chan_t'(lo)};
            SEC_GC: c = '{chan_t'(lo), chan_t'(hi), chan_t'(md)};
            SEC_CB: c = '{chan_t'(lo), chan_t'(md), chan_t'(hi)};
            SEC_BM: c = '{chan_t'(md), chan_t'(lo), chan_t'(hi)};
            default: c = '{chan_t'(hi), chan_t'(lo), chan_t'(md)};
        endcase
        return c;
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
            board.check_color(out_data);
    end

    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    task automatic write_reg(cfg_reg_t idx, coord_t v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_CENTER_X: cx_m = v;
            REG_CENTER_Y: cy_m = v;
            default: rad_m = v;
        endcase
        @(negedge clk);
    endtask

    task automatic send_point(coord_t x, coord_t y);
        in_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        p.touch_x = x;
        p.touch_y = y;
        in_valid <= 1;
        in_data <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_point(point_color(p));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic setup(coord_t cx, coord_t cy, coord_t r);
        drain();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_WHEEL_RADIUS, r);
        cfg_valid <= 0;
    endtask

    task automatic random_points(int n);
        int dx, dy, r;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                send_point(coord_t'($urandom), coord_t'($urandom));
            else
            begin
                r = rad_m + 3;
                dx = $urandom_range(2 * r) - r;
                dy = $urandom_range(2 * r) - r;
                if ($urandom_range(9) == 0)
                    dy = 0;
                else if ($urandom_range(9) == 0)
                    dx = 0;
                send_point(coord_t'(cx_m + dx), coord_t'(cy_m + dy));
            end
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        send_point(135, 135);
        send_point(263, 135);
        send_point(7, 135);
        send_point(135, 263);
        send_point(135, 7);
        send_point(200, 200);
        send_point(70, 200);
        send_point(70, 70);
        send_point(200, 70);
        send_point(0, 0);
        send_point(1023, 1023);
        send_point(264, 135);
        setup(0, 0, 0);
        send_point(0, 0);
        send_point(1, 0);
        send_point(1, 1);
        send_point(1023, 1023);
        setup(1023, 1023, 1023);
        send_point(0, 0);
        send_point(0, 1023);
        send_point(512, 300);
        send_point(1023, 1023);
        setup(512, 512, 1023);
        random_points(120);
        send_idle_pct = 63;
        setup(300, 700, 200);
        random_points(120);
        send_idle_pct = 0;
        recv_stall_pct = 63;
        setup(100, 900, 50);
        random_points(120);
        drain();
        send_idle_pct = 7;
        recv_stall_pct = 7;
        setup(cfg_data ^ 10'h2aa, 10'h155, 10'h3ff);
        random_points(120);
        drain();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/cwp_pkg.sv
rtl/cwp_front.sv
rtl/cwp_sqrt.sv
rtl/cwp_div.sv
rtl/cwp_cordic.sv
rtl/cwp_hsv.sv
rtl/color_wheel_point_to_rgb_top.sv
rtl/cwp_checker.sv
tb/tb_top.sv
